// File: hdl/mpsc_pkg.sv
package mpsc_pkg;

  // Reset value of the largest accepted media duration, in milliseconds.
  localparam logic [31:0] MaxDurationReset = 32'd86400000;

  // Largest fault code that carries a meaning.
  localparam logic [3:0] MaxFaultCode = 4'd9;

  // Playback event kinds. Codes 14 and 15 are rejected as invalid.
  typedef enum logic [3:0] {
    OpLoad      = 4'd0,
    OpLoading   = 4'd1,
    OpBuffering = 4'd2,
    OpSpkLost   = 4'd3,
    OpSpkOk     = 4'd4,
    OpReady     = 4'd5,
    OpPlay      = 4'd6,
    OpPause     = 4'd7,
    OpSeekStart = 4'd8,
    OpSeekDone  = 4'd9,
    OpPosition  = 4'd10,
    OpCompleted = 4'd11,
    OpFailed    = 4'd12,
    OpStopped   = 4'd13
  } op_e;

  // Playback states.
  typedef enum logic [3:0] {
    StIdle      = 4'd0,
    StLoading   = 4'd1,
    StWaitSpk   = 4'd2,
    StBuffering = 4'd3,
    StPlaying   = 4'd4,
    StPaused    = 4'd5,
    StSeeking   = 4'd6,
    StCompleted = 4'd7,
    StError     = 4'd8
  } play_state_e;

  // Result codes.
  typedef enum logic [2:0] {
    RcOk      = 3'd0,
    RcBadArg  = 3'd1,
    RcBadTran = 3'd2,
    RcRange   = 3'd3,
    RcProfile = 3'd4
  } outcome_e;

  // One playback event as it enters the block.
  typedef struct packed {
    logic [3:0]  op;
    logic        session_present;
    logic        profile_ok;
    logic [31:0] media_length;
    logic        auto_start;
    logic [31:0] target_position;
    logic [3:0]  fault_code;
    logic        fault_retryable;
  } event_t;

  // Architectural status of the controller.
  typedef struct packed {
    play_state_e state;
    logic        intent;
    logic        session;
    logic [31:0] duration;
    logic [31:0] position;
    logic [3:0]  error;
    logic        retry;
  } status_t;

endpackage

// File: hdl/media_playback_state_controller_top.sv
// Media playback state controller. Each input beat is one playback event; each
// event yields exactly one output beat with a result code and the status after
// the event. One event is taken every clock cycle while output beats are taken;
// only a stall on the output side holds up the input. An event is decoded in
// the input register against the current status, and the result is held in
// the output register until it is taken. A rejected event leaves the status
// unchanged. The duration limit is written through the configuration port,
// which is always ready; write it only while no events are in flight.
module media_playback_state_controller_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Event input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  op_i,
  input  logic        session_present_i,
  input  logic        profile_ok_i,
  input  logic [31:0] media_length_i,
  input  logic        auto_start_i,
  input  logic [31:0] target_position_i,
  input  logic [3:0]  fault_code_i,
  input  logic        fault_retryable_i,
  // Result output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  outcome_o,
  output logic [3:0]  play_state_o,
  output logic        intent_playing_o,
  output logic        session_valid_o,
  output logic [31:0] position_now_o,
  output logic [3:0]  error_now_o,
  output logic        retry_now_o,
  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  logic               ev_valid_q;
  mpsc_pkg::event_t   ev_q;
  logic               out_valid_q;
  mpsc_pkg::outcome_e outcome_q;
  mpsc_pkg::status_t  res_q;

  logic               out_free;
  logic               ev_adv;
  logic               in_acc;
  mpsc_pkg::status_t  status_q;
  mpsc_pkg::status_t  status_d;
  mpsc_pkg::outcome_e outcome_d;
  logic [31:0]        max_duration;

  // Handshake: the output register frees up when empty or being taken.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign ev_adv     = ev_valid_q && out_free;
  assign in_stall_o = ev_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      ev_valid_q <= in_valid_i;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ev_q.op              <= op_i;
      ev_q.session_present <= session_present_i;
      ev_q.profile_ok      <= profile_ok_i;
      ev_q.media_length    <= media_length_i;
      ev_q.auto_start      <= auto_start_i;
      ev_q.target_position <= target_position_i;
      ev_q.fault_code      <= fault_code_i;
      ev_q.fault_retryable <= fault_retryable_i;
    end
  end

  // Event decode against the current status.
  mpsc_eval u_eval (
    .ev_i           (ev_q),
    .cur_i          (status_q),
    .max_duration_i (max_duration),
    .outcome_o      (outcome_d),
    .nxt_o          (status_d)
  );

  // Status and configuration registers.
  mpsc_status u_status (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .upd_i          (ev_adv),
    .status_d_i     (status_d),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .status_q_o     (status_q),
    .max_duration_o (max_duration)
  );

  assign cfg_ready_o = 1'b1;

  // Output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= ev_valid_q;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (ev_adv) begin
      outcome_q <= outcome_d;
      res_q     <= status_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign outcome_o        = outcome_q;
  assign play_state_o     = res_q.state;
  assign intent_playing_o = res_q.intent;
  assign session_valid_o  = res_q.session;
  assign position_now_o   = res_q.position;
  assign error_now_o      = res_q.error;
  assign retry_now_o      = res_q.retry;

`ifndef SYNTHESIS
  // The input side only stalls behind a full, backpressured output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output register could advance");

  // The error state always carries a stored error code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (play_state_o == mpsc_pkg::StError)) |-> (error_now_o != 4'd0))
    else $error("error state without an error code");

  // Idle means no session is loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (play_state_o == mpsc_pkg::StIdle)) |-> !session_valid_o)
    else $error("idle state with a loaded session");

  // Without a session the position stays at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !session_valid_o) |-> (position_now_o == 32'd0))
    else $error("nonzero position without a session");
`endif

endmodule

// File: hdl/mpsc_eval.sv
module mpsc_eval (
  input  mpsc_pkg::event_t   ev_i,
  input  mpsc_pkg::status_t  cur_i,
  input  logic [31:0]        max_duration_i,
  output mpsc_pkg::outcome_e outcome_o,
  output mpsc_pkg::status_t  nxt_o
);

  logic                   active;
  logic                   pos_in_range;
  mpsc_pkg::play_state_e  settled;

  // An active session is loaded and has left idle.
  assign active       = cur_i.session && (cur_i.state != mpsc_pkg::StIdle);
  assign pos_in_range = ev_i.target_position <= cur_i.duration;
  assign settled      = cur_i.intent ? mpsc_pkg::StPlaying : mpsc_pkg::StPaused;

  // Event decode. A rejected event leaves the status as it was.
  always_comb begin
    nxt_o     = cur_i;
    outcome_o = mpsc_pkg::RcOk;
    case (ev_i.op)
      mpsc_pkg::OpLoad: begin
        if (!ev_i.session_present) begin
          outcome_o = mpsc_pkg::RcBadArg;
        end else if (!ev_i.profile_ok) begin
          outcome_o = mpsc_pkg::RcProfile;
        end else if ((ev_i.media_length == 32'd0) ||
                     (ev_i.media_length > max_duration_i)) begin
          outcome_o = mpsc_pkg::RcRange;
        end else begin
          nxt_o.duration = ev_i.media_length;
          nxt_o.session  = 1'b1;
          nxt_o.state    = mpsc_pkg::StLoading;
          nxt_o.intent   = ev_i.auto_start;
          nxt_o.position = 32'd0;
          nxt_o.error    = 4'd0;
          nxt_o.retry    = 1'b0;
        end
      end
      mpsc_pkg::OpLoading: begin
        if (!active || (cur_i.state == mpsc_pkg::StError)) begin
          outcome_o = mpsc_pkg::RcBadTran;
        end else begin
          nxt_o.state = mpsc_pkg::StLoading;
        end
      end
      mpsc_pkg::OpBuffering, mpsc_pkg::OpSpkLost: begin
        if (!active || (cur_i.state inside {mpsc_pkg::StError, mpsc_pkg::StCompleted})) begin
          outcome_o = mpsc_pkg::RcBadTran;
        end else if (ev_i.op == mpsc_pkg::OpBuffering) begin
          nxt_o.state = mpsc_pkg::StBuffering;
        end else begin
          nxt_o.state = mpsc_pkg::StWaitSpk;
        end
      end
      mpsc_pkg::OpSpkOk: begin
        if ((cur_i.state != mpsc_pkg::StWaitSpk) || !cur_i.session) begin
          outcome_o = mpsc_pkg::RcBadTran;
        end else begin
          nxt_o.state = mpsc_pkg::StBuffering;
        end
      end
      mpsc_pkg::OpReady: begin
        if (!active || !(cur_i.state inside {mpsc_pkg::StLoading, mpsc_pkg::StBuffering,
                                             mpsc_pkg::StSeeking, mpsc_pkg::StWaitSpk})) begin
          outcome_o = mpsc_pkg::RcBadTran;
        end else begin
          nxt_o.state = settled;
        end
      end
      mpsc_pkg::OpPlay, mpsc_pkg::OpPause: begin
        if (!active || !(cur_i.state inside {mpsc_pkg::StLoading, mpsc_pkg::StWaitSpk,
                                             mpsc_pkg::StBuffering, mpsc_pkg::StPlaying,
                                             mpsc_pkg::StPaused, mpsc_pkg::StSeeking})) begin
          outcome_o = mpsc_pkg::RcBadTran;
        end else if (ev_i.op == mpsc_pkg::OpPlay) begin
          nxt_o.intent = 1'b1;
          if (cur_i.state == mpsc_pkg::StPaused) begin
            nxt_o.state = mpsc_pkg::StPlaying;
          end
        end else begin
          nxt_o.intent = 1'b0;
          if (cur_i.state == mpsc_pkg::StPlaying) begin
            nxt_o.state = mpsc_pkg::StPaused;
          end
        end
      end
      mpsc_pkg::OpSeekStart: begin
        if (!active || !(cur_i.state inside {mpsc_pkg::StWaitSpk, mpsc_pkg::StBuffering,
                                             mpsc_pkg::StPlaying, mpsc_pkg::StPaused,
                                             mpsc_pkg::StCompleted})) begin
          outcome_o = mpsc_pkg::RcBadTran;
        end else if (!pos_in_range) begin
          outcome_o = mpsc_pkg::RcRange;
        end else begin
          nxt_o.position = ev_i.target_position;
          nxt_o.state    = mpsc_pkg::StSeeking;
        end
      end
      mpsc_pkg::OpSeekDone: begin
        // Seeking is never idle, so a loaded session here is an active one.
        if ((cur_i.state != mpsc_pkg::StSeeking) || !cur_i.session) begin
          outcome_o = mpsc_pkg::RcBadTran;
        end else if (!pos_in_range) begin
          outcome_o = mpsc_pkg::RcRange;
        end else begin
          nxt_o.position = ev_i.target_position;
          nxt_o.state    = settled;
        end
      end
      mpsc_pkg::OpPosition: begin
        if (!active) begin
          outcome_o = mpsc_pkg::RcBadTran;
        end else if (!pos_in_range) begin
          outcome_o = mpsc_pkg::RcRange;
        end else begin
          nxt_o.position = ev_i.target_position;
        end
      end
      mpsc_pkg::OpCompleted: begin
        if (!active || !(cur_i.state inside {mpsc_pkg::StPlaying, mpsc_pkg::StBuffering})) begin
          outcome_o = mpsc_pkg::RcBadTran;
        end else begin
          nxt_o.position = cur_i.duration;
          nxt_o.intent   = 1'b0;
          nxt_o.state    = mpsc_pkg::StCompleted;
        end
      end
      mpsc_pkg::OpFailed: begin
        // Accepted in any state, but only with a meaningful fault code.
        if ((ev_i.fault_code == 4'd0) || (ev_i.fault_code > mpsc_pkg::MaxFaultCode)) begin
          outcome_o = mpsc_pkg::RcBadArg;
        end else begin
          nxt_o.state = mpsc_pkg::StError;
          nxt_o.error = ev_i.fault_code;
          nxt_o.retry = ev_i.fault_retryable;
        end
      end
      mpsc_pkg::OpStopped: begin
        nxt_o.session  = 1'b0;
        nxt_o.duration = 32'd0;
        nxt_o.position = 32'd0;
        nxt_o.intent   = 1'b0;
        nxt_o.error    = 4'd0;
        nxt_o.retry    = 1'b0;
        nxt_o.state    = mpsc_pkg::StIdle;
      end
      default: begin
        outcome_o = mpsc_pkg::RcBadArg;
      end
    endcase
  end

endmodule

// File: hdl/mpsc_status.sv
module mpsc_status (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              upd_i,
  input  mpsc_pkg::status_t status_d_i,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_data_i,
  output mpsc_pkg::status_t status_q_o,
  output logic [31:0]       max_duration_o
);

  mpsc_pkg::status_t status_q;
  logic [31:0]       max_duration_q;

  // Playback status, updated once for each event that leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q.state    <= mpsc_pkg::StIdle;
      status_q.intent   <= 1'b0;
      status_q.session  <= 1'b0;
      status_q.duration <= 32'd0;
      status_q.position <= 32'd0;
      status_q.error    <= 4'd0;
      status_q.retry    <= 1'b0;
    end else if (upd_i) begin
      status_q <= status_d_i;
    end
  end

  // Duration limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_duration_q <= mpsc_pkg::MaxDurationReset;
    end else if (cfg_we_i) begin
      max_duration_q <= cfg_data_i;
    end
  end

  assign status_q_o     = status_q;
  assign max_duration_o = max_duration_q;

endmodule
